[rtl/core/jpeg_coef_run_expander_unit_defines.svh]
// Assertion macros shared by the run expander RTL.
// Included by every module that carries concurrent checks; no other dependencies.
`ifndef JPEG_COEF_RUN_EXPANDER_UNIT_DEFINES_SVH
`define JPEG_COEF_RUN_EXPANDER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define JCRE_ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define JCRE_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define JCRE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define JCRE_ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define JCRE_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define JCRE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

[rtl/core/jcre_pkg.sv]
// Types, constants and the VLI decode function of the coefficient run expander.
// No dependencies; used by every module of the block.
`default_nettype none

package jcre_pkg;

  localparam int BLOCK_COEFS = 64;
  localparam int POS_W       = $clog2(BLOCK_COEFS);
  localparam int EOB_W       = POS_W + 1;
  localparam int SYM_W       = 8;
  localparam int BITS_W      = 15;
  localparam int VAL_W       = 16;
  localparam int ERR_W       = 2;

  localparam int CMD_DEPTH   = 2;
  localparam int CMD_PTR_W   = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CMD_CNT_W   = $clog2(CMD_DEPTH + 1);

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE    = 2'd0,
    ERR_CODE    = 2'd1,
    ERR_OVERRUN = 2'd2
  } jcre_err_e;

  // One classified symbol: zero writes from start_idx, then one final result.
  typedef struct packed {
    logic [POS_W-1:0]        start_idx;
    logic [POS_W-1:0]        zero_cnt;
    logic                    fin_write;
    logic signed [VAL_W-1:0] fin_value;
    logic                    done;
    logic [EOB_W-1:0]        eob;
    jcre_err_e               err;
  } jcre_cmd_t;

  typedef struct packed {
    logic [POS_W-1:0]        idx;
    logic signed [VAL_W-1:0] value;
    logic                    write;
    logic                    last;
    logic                    done;
    logic [EOB_W-1:0]        eob;
    jcre_err_e               err;
  } jcre_res_t;

  // JPEG VLI: leading 1 means positive, leading 0 means value minus mask.
  function automatic logic signed [VAL_W-1:0] jcre_vli(input logic [3:0] size,
                                                      input logic [BITS_W-1:0] bits);
    logic [VAL_W-1:0] mask;
    logic [VAL_W-1:0] mag;
    logic [3:0]       top;
    mask = (VAL_W'(1) << size) - VAL_W'(1);
    mag  = {1'b0, bits} & mask;
    top  = size - 4'd1;
    if (size == 4'd0) begin
      return '0;
    end
    if (mag[top]) begin
      return signed'(mag);
    end
    return signed'(mag - mask);
  endfunction

endpackage

`default_nettype wire

[rtl/core/jcre_front.sv]
// Front end: tracks the coefficient position and classifies each symbol into a command.
// Depends on jcre_pkg and the assertion macro header.
`default_nettype none
`include "jpeg_coef_run_expander_unit_defines.svh"

module jcre_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         accept_i,
  input  wire logic [jcre_pkg::SYM_W-1:0]   symbol_i,
  input  wire logic [jcre_pkg::BITS_W-1:0]  extra_bits_i,
  input  wire logic                         code_error_i,
  input  wire logic                         stream_at_eof_i,
  output jcre_pkg::jcre_cmd_t               cmd_o
);
  import jcre_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d, pos_cls;
  logic [3:0]       run, size;
  logic [POS_W:0]   run_end;
  logic [POS_W:0]   next_pos;
  jcre_cmd_t        cmd;

  assign run      = symbol_i[7:4];
  assign size     = symbol_i[3:0];
  assign run_end  = {1'b0, pos_q} + (POS_W+1)'(run);
  assign next_pos = run_end + (POS_W+1)'(1);

  always_comb begin
    cmd           = '0;
    cmd.err       = ERR_NONE;
    cmd.start_idx = pos_q;
    pos_cls       = '0;
    priority if (code_error_i) begin
      cmd.done = 1'b1;
      cmd.err  = ERR_CODE;
    end else if (pos_q == '0) begin
      if (symbol_i > SYM_W'(15)) begin
        cmd.done = 1'b1;
        cmd.err  = ERR_CODE;
      end else begin
        cmd.fin_write = 1'b1;
        cmd.fin_value = jcre_vli(size, extra_bits_i);
        pos_cls       = POS_W'(1);
      end
    end else if (symbol_i == '0) begin
      cmd.done = 1'b1;
      cmd.eob  = {1'b0, pos_q};
    end else if (run_end >= (POS_W+1)'(BLOCK_COEFS)) begin
      // Truncated block: fill with zeros and plant a 1 in the last slot.
      cmd.zero_cnt  = POS_W'(BLOCK_COEFS - 1) - pos_q;
      cmd.fin_write = 1'b1;
      cmd.fin_value = VAL_W'(1);
      cmd.done      = 1'b1;
      cmd.eob       = EOB_W'(BLOCK_COEFS);
      cmd.err       = stream_at_eof_i ? ERR_NONE : ERR_OVERRUN;
    end else begin
      cmd.zero_cnt  = POS_W'(run);
      cmd.fin_write = 1'b1;
      cmd.fin_value = jcre_vli(size, extra_bits_i);
      if (next_pos == (POS_W+1)'(BLOCK_COEFS)) begin
        cmd.done = 1'b1;
        cmd.eob  = EOB_W'(BLOCK_COEFS);
      end else begin
        pos_cls = next_pos[POS_W-1:0];
      end
    end
  end

  assign pos_d = accept_i ? pos_cls : pos_q;
  assign cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  `JCRE_ASSERT_NEXT(a_err_restarts_block, clk_i, rst_ni, accept_i && code_error_i,
    pos_q == '0, "position not cleared after invalid code")
  `JCRE_ASSERT_IMPL(a_done_has_final, clk_i, rst_ni, cmd.fin_write && cmd.done && !code_error_i,
    cmd.start_idx + cmd.zero_cnt == POS_W'(BLOCK_COEFS - 1), "block end not at last slot")

endmodule

`default_nettype wire

[rtl/core/jcre_cmd_fifo.sv]
// Short command queue between the front end and the expander back end.
// Depends on jcre_pkg and the assertion macro header.
`default_nettype none
`include "jpeg_coef_run_expander_unit_defines.svh"

module jcre_cmd_fifo (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire jcre_pkg::jcre_cmd_t wdata_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output jcre_pkg::jcre_cmd_t rdata_o,
  output logic              empty_o
);
  import jcre_pkg::*;

  jcre_cmd_t            mem_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CMD_CNT_W-1:0] cnt_q, cnt_d;
  logic                 do_push, do_pop;

  function automatic logic [CMD_PTR_W-1:0] bump(input logic [CMD_PTR_W-1:0] p);
    return (p == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : p + CMD_PTR_W'(1);
  endfunction

  assign full_o  = (cnt_q == CMD_CNT_W'(CMD_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? bump(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? bump(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CMD_CNT_W'(1);
      2'b01:   cnt_d = cnt_q - CMD_CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  `JCRE_ASSERT_ALWAYS(a_cnt_bound, clk_i, rst_ni, cnt_q <= CMD_CNT_W'(CMD_DEPTH),
    "command queue count out of range")

endmodule

`default_nettype wire

[rtl/core/jcre_back.sv]
// Back end: expands commands into an output register, one result per cycle if popped.
// Depends on jcre_pkg and the assertion macro header.
`default_nettype none
`include "jpeg_coef_run_expander_unit_defines.svh"

module jcre_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire jcre_pkg::jcre_cmd_t cmd_i,
  input  wire logic           cmd_valid_i,
  output logic                cmd_pop_o,
  output jcre_pkg::jcre_res_t res_o,
  output logic                res_valid_o,
  input  wire logic           res_pop_i
);
  import jcre_pkg::*;

  logic [POS_W-1:0] zcnt_q, zcnt_d;
  jcre_res_t        out_q, res;
  logic             out_valid_q, out_valid_d;
  logic             emit_zero, slot_free, load;

  assign emit_zero = (zcnt_q != cmd_i.zero_cnt);
  assign slot_free = !out_valid_q || res_pop_i;
  assign load      = cmd_valid_i && slot_free;
  assign cmd_pop_o = load && !emit_zero;

  always_comb begin
    res       = '0;
    res.err   = ERR_NONE;
    res.write = emit_zero || cmd_i.fin_write;
    if (res.write) begin
      res.idx = cmd_i.start_idx + zcnt_q;
    end
    if (!emit_zero) begin
      res.value = cmd_i.fin_value;
      res.last  = 1'b1;
      res.done  = cmd_i.done;
      res.eob   = cmd_i.done ? cmd_i.eob : '0;
      res.err   = cmd_i.err;
    end
  end

  always_comb begin
    zcnt_d      = zcnt_q;
    out_valid_d = out_valid_q;
    if (load) begin
      // Advance through the zero run, restart on the final result.
      zcnt_d      = emit_zero ? zcnt_q + POS_W'(1) : '0;
      out_valid_d = 1'b1;
    end else if (res_pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      zcnt_q      <= zcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign res_o       = out_q;
  assign res_valid_o = out_valid_q;

  `JCRE_ASSERT_IMPL(a_zcnt_in_run, clk_i, rst_ni, cmd_valid_i, zcnt_q <= cmd_i.zero_cnt,
    "zero counter ran past the command run")
  `JCRE_ASSERT_IMPL(a_done_is_last, clk_i, rst_ni, out_valid_q && out_q.done, out_q.last,
    "block end on a result that is not last")

endmodule

`default_nettype wire

[rtl/core/jpeg_coef_run_expander_unit.sv]
// Top level of the JPEG coefficient run expander: front end, command queue, back end.
// Depends on jcre_pkg, jcre_front, jcre_cmd_fifo and jcre_back.
//
// Takes one Huffman-decoded symbol per item and writes out the coefficient results of
// one 8x8 block in zigzag order, one result per cycle while pop keeps up. The front
// end classifies a symbol in the cycle it is accepted, so push may be high every
// cycle while the two-entry command queue has room. The back end then emits run zero
// writes and then the value for an AC symbol, a single result for DC, EOB or an
// error, and up to BLOCK_COEFS-1 results for a truncated block filled with zeros.
// Sustained rate is thus set by the back end's one result per cycle; results wait in an
// output register, so a stalled pop does not stop the front end until the queue fills.
`default_nettype none

module jpeg_coef_run_expander_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic [jcre_pkg::SYM_W-1:0]          symbol_i,
  input  wire logic [jcre_pkg::BITS_W-1:0]         extra_bits_i,
  input  wire logic                                code_error_i,
  input  wire logic                                stream_at_eof_i,
  output logic                                     empty,
  input  wire logic                                pop,
  output logic [jcre_pkg::POS_W-1:0]               coef_index_o,
  output logic signed [jcre_pkg::VAL_W-1:0]        coef_value_o,
  output logic                                     coef_write_o,
  output logic                                     last_o,
  output logic                                     block_done_o,
  output logic [jcre_pkg::EOB_W-1:0]               eob_position_o,
  output logic [jcre_pkg::ERR_W-1:0]               error_code_o
);
  import jcre_pkg::*;

  jcre_cmd_t cmd_in, cmd_head;
  jcre_res_t res;
  logic      accept, q_full, q_empty, q_pop, res_valid;

  assign accept = push && !q_full;
  assign full   = q_full;

  jcre_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .symbol_i        (symbol_i),
    .extra_bits_i    (extra_bits_i),
    .code_error_i    (code_error_i),
    .stream_at_eof_i (stream_at_eof_i),
    .cmd_o           (cmd_in)
  );

  jcre_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .wdata_i (cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (cmd_head),
    .empty_o (q_empty)
  );

  jcre_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_head),
    .cmd_valid_i (!q_empty),
    .cmd_pop_o   (q_pop),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_pop_i   (pop)
  );

  assign empty          = !res_valid;
  assign coef_index_o   = res.idx;
  assign coef_value_o   = res.value;
  assign coef_write_o   = res.write;
  assign last_o         = res.last;
  assign block_done_o   = res.done;
  assign eob_position_o = res.eob;
  assign error_code_o   = res.err;

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench of jpeg_coef_run_expander_unit: directed table, then random blocks.
// Depends on jcre_pkg and the RTL of the block; a local model or a chk row predicts every result.

module tb_top;
  import jcre_pkg::*;

  localparam int ITEM_TARGET    = 430;
  localparam int CALM_ITEMS     = 60;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TAIL_CYCLES    = 20;
  localparam int REPORT_MAX     = 10;

  typedef struct packed {
    logic [SYM_W-1:0]        sym;
    logic [BITS_W-1:0]       bits;
    logic                    bad_code;
    logic                    at_eof;
    logic                    chk;
    logic [POS_W-1:0]        e_idx;
    logic signed [VAL_W-1:0] e_val;
    logic                    e_wr;
    logic                    e_done;
    logic [EOB_W-1:0]        e_eob;
    jcre_err_e               e_err;
  } stim_row_t;

  // chk rows carry their single result inline; the others use the coefficient model
  localparam stim_row_t DIRECTED_TAB [24] = '{
    '{8'h00, 15'h0000, 1'b0, 1'b0, 1'b1, 6'd0,  16'sd0,      1'b1, 1'b0, 7'd0,  ERR_NONE},
    '{8'h00, 15'h7fff, 1'b0, 1'b1, 1'b1, 6'd0,  16'sd0,      1'b0, 1'b1, 7'd1,  ERR_NONE},
    '{8'h0f, 15'h7fff, 1'b0, 1'b0, 1'b1, 6'd0,  16'sd32767,  1'b1, 1'b0, 7'd0,  ERR_NONE},
    '{8'h0f, 15'h0000, 1'b0, 1'b1, 1'b1, 6'd1, -16'sd32767,  1'b1, 1'b0, 7'd0,  ERR_NONE},
    '{8'hf0, 15'h7fff, 1'b0, 1'b0, 1'b0, 6'd0,  16'sd0,      1'b0, 1'b0, 7'd0,  ERR_NONE},
    '{8'h30, 15'h5555, 1'b0, 1'b1, 1'b0, 6'd0,  16'sd0,      1'b0, 1'b0, 7'd0,  ERR_NONE},
    '{8'h21, 15'h2aaa, 1'b0, 1'b0, 1'b0, 6'd0,  16'sd0,      1'b0, 1'b0, 7'd0,  ERR_NONE},
    '{8'h01, 15'h0001, 1'b0, 1'b0, 1'b1, 6'd25, 16'sd1,      1'b1, 1'b0, 7'd0,  ERR_NONE},
    '{8'h00, 15'h0000, 1'b0, 1'b0, 1'b1, 6'd0,  16'sd0,      1'b0, 1'b1, 7'd26, ERR_NONE},
    '{8'h10, 15'h0000, 1'b0, 1'b0, 1'b1, 6'd0,  16'sd0,      1'b0, 1'b1, 7'd0,  ERR_CODE},
    '{8'hff, 15'h7fff, 1'b0, 1'b1, 1'b1, 6'd0,  16'sd0,      1'b0, 1'b1, 7'd0,  ERR_CODE},
    '{8'h55, 15'h1234, 1'b1, 1'b0, 1'b1, 6'd0,  16'sd0,      1'b0, 1'b1, 7'd0,  ERR_CODE},
    '{8'h05, 15'h0000, 1'b0, 1'b0, 1'b1, 6'd0, -16'sd31,     1'b1, 1'b0, 7'd0,  ERR_NONE},
    '{8'h00, 15'h0000, 1'b1, 1'b1, 1'b1, 6'd0,  16'sd0,      1'b0, 1'b1, 7'd0,  ERR_CODE},
    '{8'h01, 15'h0000, 1'b0, 1'b0, 1'b1, 6'd0, -16'sd1,      1'b1, 1'b0, 7'd0,  ERR_NONE},
    '{8'hf0, 15'h0000, 1'b0, 1'b0, 1'b0, 6'd0,  16'sd0,      1'b0, 1'b0, 7'd0,  ERR_NONE},
    '{8'hf0, 15'h0000, 1'b0, 1'b0, 1'b0, 6'd0,  16'sd0,      1'b0, 1'b0, 7'd0,  ERR_NONE},
    '{8'hf0, 15'h0000, 1'b0, 1'b0, 1'b0, 6'd0,  16'sd0,      1'b0, 1'b0, 7'd0,  ERR_NONE},
    '{8'he0, 15'h0000, 1'b0, 1'b0, 1'b0, 6'd0,  16'sd0,      1'b0, 1'b0, 7'd0,  ERR_NONE},
    '{8'h0b, 15'h07ff, 1'b0, 1'b0, 1'b1, 6'd0,  16'sd2047,   1'b1, 1'b0, 7'd0,  ERR_NONE},
    '{8'hf0, 15'h0000, 1'b0, 1'b0, 1'b0, 6'd0,  16'sd0,      1'b0, 1'b0, 7'd0,  ERR_NONE},
    '{8'hf0, 15'h0000, 1'b0, 1'b0, 1'b0, 6'd0,  16'sd0,      1'b0, 1'b0, 7'd0,  ERR_NONE},
    '{8'hf0, 15'h0000, 1'b0, 1'b0, 1'b0, 6'd0,  16'sd0,      1'b0, 1'b0, 7'd0,  ERR_NONE},
    '{8'hf3, 15'h0005, 1'b0, 1'b0, 1'b0, 6'd0,  16'sd0,      1'b0, 1'b0, 7'd0,  ERR_NONE}
  };

  logic                    clk_i;
  logic                    rst_ni;
  logic                    push;
  logic                    full;
  logic [SYM_W-1:0]        symbol;
  logic [BITS_W-1:0]       extra_bits;
  logic                    code_error;
  logic                    stream_at_eof;
  logic                    empty;
  logic                    pop;
  logic [POS_W-1:0]        coef_index;
  logic signed [VAL_W-1:0] coef_value;
  logic                    coef_write;
  logic                    last;
  logic                    block_done;
  logic [EOB_W-1:0]        eob_position;
  logic [ERR_W-1:0]        error_code;

  jcre_res_t  coef_expect_q [$];
  logic [6:0] block_pos;
  int         items_sent;
  int         err_count;
  bit         idle_on;

  jpeg_coef_run_expander_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .symbol_i        (symbol),
    .extra_bits_i    (extra_bits),
    .code_error_i    (code_error),
    .stream_at_eof_i (stream_at_eof),
    .empty           (empty),
    .pop             (pop),
    .coef_index_o    (coef_index),
    .coef_value_o    (coef_value),
    .coef_write_o    (coef_write),
    .last_o          (last),
    .block_done_o    (block_done),
    .eob_position_o  (eob_position),
    .error_code_o    (error_code)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // JPEG magnitude rule: upper half of the range is positive, lower half negative
  function automatic logic signed [VAL_W-1:0] decode_magnitude(input logic [3:0] size,
                                                               input logic [BITS_W-1:0] raw);
    int unsigned span;
    int unsigned mag;
    if (size == 4'd0) return '0;
    span = 1 << size;
    mag  = raw % span;
    if (mag >= span / 2) return VAL_W'(mag);
    return VAL_W'(int'(mag) - int'(span) + 1);
  endfunction

  function automatic void push_result(input int idx, input int val, input bit wr, input bit lst,
                                      input bit dn, input int eob, input jcre_err_e err);
    jcre_res_t r;
    r.idx   = POS_W'(idx);
    r.value = VAL_W'(val);
    r.write = wr;
    r.last  = lst;
    r.done  = dn;
    r.eob   = EOB_W'(eob);
    r.err   = err;
    coef_expect_q.push_back(r);
  endfunction

  function automatic void expand_symbol(input logic [SYM_W-1:0] sym,
                                        input logic [BITS_W-1:0] raw,
                                        input logic bad_code, input logic at_eof);
    int unsigned pos;
    int unsigned run;
    int unsigned p;
    pos = block_pos;
    run = sym[7:4];
    if (pos >= BLOCK_COEFS) pos = 0;
    if (bad_code || (pos == 0 && sym > 15)) begin
      push_result(0, 0, 1'b0, 1'b1, 1'b1, 0, ERR_CODE);
      block_pos = '0;
      return;
    end
    if (pos == 0) begin
      push_result(0, decode_magnitude(sym[3:0], raw), 1'b1, 1'b1, 1'b0, 0, ERR_NONE);
      block_pos = 7'd1;
      return;
    end
    if (sym == '0) begin
      push_result(0, 0, 1'b0, 1'b1, 1'b1, pos, ERR_NONE);
      block_pos = '0;
      return;
    end
    if (run + pos >= BLOCK_COEFS) begin
      // truncated block: zero fill, then 1 in the last slot
      for (p = pos; p + 1 < BLOCK_COEFS; p++)
        push_result(p, 0, 1'b1, 1'b0, 1'b0, 0, ERR_NONE);
      push_result(BLOCK_COEFS - 1, 1, 1'b1, 1'b1, 1'b1, BLOCK_COEFS,
                  at_eof ? ERR_NONE : ERR_OVERRUN);
      block_pos = '0;
      return;
    end
    for (p = 0; p < run; p++)
      push_result(pos + p, 0, 1'b1, 1'b0, 1'b0, 0, ERR_NONE);
    pos = pos + run;
    if (pos + 1 >= BLOCK_COEFS) begin
      push_result(pos, decode_magnitude(sym[3:0], raw), 1'b1, 1'b1, 1'b1, BLOCK_COEFS,
                  ERR_NONE);
      block_pos = '0;
    end else begin
      push_result(pos, decode_magnitude(sym[3:0], raw), 1'b1, 1'b1, 1'b0, 0, ERR_NONE);
      block_pos = 7'(pos + 1);
    end
  endfunction

  function automatic stim_row_t make_row(input logic [SYM_W-1:0] sym, input logic bad_code);
    stim_row_t row;
    row          = '0;
    row.sym      = sym;
    row.bits     = BITS_W'($urandom());
    row.bad_code = bad_code;
    row.at_eof   = 1'($urandom_range(0, 1));
    row.e_err    = ERR_NONE;
    return row;
  endfunction

  // Starts at a falling edge, returns at the rising edge that accepts the item.
  task automatic send_item(input stim_row_t row);
    int gap;
    int n_before;
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap  = $urandom_range(1, 4);
      push = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push          = 1'b1;
    symbol        = row.sym;
    extra_bits    = row.bits;
    code_error    = row.bad_code;
    stream_at_eof = row.at_eof;
    do @(posedge clk_i); while (full);
    n_before = coef_expect_q.size();
    expand_symbol(row.sym, row.bits, row.bad_code, row.at_eof);
    if (row.chk) begin
      while (coef_expect_q.size() > n_before) coef_expect_q.delete(coef_expect_q.size() - 1);
      push_result(row.e_idx, row.e_val, row.e_wr, 1'b1, row.e_done, row.e_eob, row.e_err);
    end
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    push = 1'b0;
    while (coef_expect_q.size() != 0) @(posedge clk_i);
  endtask

  // One DC symbol, then AC pairs, EOBs or bad codes until the block ends; now and then a stray item instead.
  task automatic send_random_block();
    int          pick;
    logic [3:0]  run;
    logic [3:0]  size;
    if ($urandom_range(0, 11) == 0) begin
      send_item(make_row(SYM_W'($urandom()), 1'($urandom_range(0, 1))));
      return;
    end
    if ($urandom_range(0, 19) == 0)
      send_item(make_row(SYM_W'($urandom_range(16, 255)), 1'b0));
    else if ($urandom_range(0, 7) == 0)
      send_item(make_row(SYM_W'($urandom_range(12, 15)), 1'b0));
    else
      send_item(make_row(SYM_W'($urandom_range(0, 11)), 1'b0));
    while (block_pos != '0) begin
      pick = $urandom_range(0, 99);
      run  = 4'($urandom_range(0, 3));
      size = 4'($urandom_range(0, 15));
      if (pick < 6) begin
        send_item(make_row(8'h00, 1'b0));
      end else if (pick < 9) begin
        send_item(make_row(SYM_W'($urandom()), 1'b1));
      end else if (pick < 25) begin
        // long runs push the position toward the end of the block
        send_item(make_row({4'hf, ($urandom_range(0, 1) == 0) ? 4'h0 : size}, 1'b0));
      end else begin
        if (pick < 40) run = 4'($urandom_range(4, 15));
        send_item(make_row({run, size}, 1'b0));
      end
    end
  endtask

  initial begin
    bit paused_once;
    paused_once   = 1'b0;
    push          = 1'b0;
    symbol        = '0;
    extra_bits    = '0;
    code_error    = 1'b0;
    stream_at_eof = 1'b0;
    block_pos     = '0;
    items_sent    = 0;
    err_count     = 0;
    idle_on       = 1'b1;
    rst_ni        = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    foreach (DIRECTED_TAB[i]) send_item(DIRECTED_TAB[i]);
    wait_drained();
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= ITEM_TARGET - CALM_ITEMS) idle_on = 1'b0;
      if (!paused_once && items_sent >= ITEM_TARGET / 2) begin
        wait_drained();
        paused_once = 1'b1;
      end
      send_random_block();
    end
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int stall;
    stall = 0;
    pop   = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        pop = 1'b0;
        stall--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        pop   = 1'b0;
        stall = $urandom_range(1, 4) - 1;
      end else begin
        pop = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    jcre_res_t want;
    if (rst_ni && pop && !empty) begin
      if (coef_expect_q.size() == 0) begin
        err_count++;
        if (err_count <= REPORT_MAX)
          $display("unexpected result: idx %0d value %0d write %0b last %0b done %0b",
                   coef_index, coef_value, coef_write, last, block_done);
      end else begin
        want = coef_expect_q.pop_front();
        if (coef_index !== want.idx || coef_value !== want.value ||
            coef_write !== want.write || last !== want.last || block_done !== want.done ||
            eob_position !== want.eob || error_code !== want.err) begin
          err_count++;
          if (err_count <= REPORT_MAX)
            $display("mismatch: exp idx %0d val %0d wr %0b last %0b done %0b eob %0d err %0d",
                     want.idx, want.value, want.write, want.last, want.done, want.eob,
                     want.err, "\n          got idx %0d val %0d wr %0b last %0b done %0b",
                     coef_index, coef_value, coef_write, last, block_done,
                     " eob %0d err %0d", eob_position, error_code);
        end
      end
    end
  end

  // Abort when neither side moves an item for too long.
  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty))
        quiet = 0;
      else
        quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/jcre_pkg.sv
rtl/core/jcre_front.sv
rtl/core/jcre_cmd_fifo.sv
rtl/core/jcre_back.sv
rtl/core/jpeg_coef_run_expander_unit.sv
tb/sv/tb_top.sv
